@@ design/assert_macros.svh @@
// assertion macros shared by the parser unit
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/dsp_pkg.sv @@
// types and constants of the decimal integer stream parser
// no dependencies; imported by the top module, dsp_front and dsp_back, but not by dsp_fifo
`timescale 1ns / 1ps

package dsp_pkg;

    localparam int ACC_W      = 63;
    localparam int CFG_ADDR_W = 2;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [ACC_W-1:0] LIMIT_NARROW = 63'd214748364;
    localparam logic [ACC_W-1:0] LIMIT_WIDE   = 63'd922337203685477580;

    localparam logic [CFG_ADDR_W-1:0] REG_SIGN_ENABLE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDE_MODE   = 2'd1;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] parsed_value;
        logic               digits_seen;
        logic               digits_dropped;
    } t_out_item;

    typedef enum logic [1:0] {
        TK_NUL   = 2'd0,
        TK_DIGIT = 2'd1,
        TK_MINUS = 2'd2,
        TK_OTHER = 2'd3
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind  kind;
        logic [3:0] digit;
        logic       eot;
    } t_token;

    typedef struct packed {
        logic [ACC_W-1:0] magnitude;
        logic             negative;
        logic             digits_seen;
        logic             digits_dropped;
    } t_result;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_MINUS  = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

endpackage

@@ design/decimal_integer_stream_parser_unit.sv @@
// decimal integer stream parser: one text byte per transfer in, parsed numbers out
// a finishing byte's token is queued, then dsp_back pushes its result into the result queue
// throughput: one byte per cycle while no queue is full, set by the shift-add in dsp_back
// reset (synchronous, active low): queues empty, parser skipping, sign_enable 1, wide_mode 0
// depends on dsp_pkg, dsp_fifo, dsp_front, dsp_back and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module decimal_integer_stream_parser_unit #(
    parameter int TOKEN_DEPTH  = 4,
    parameter int RESULT_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  dsp_pkg::t_in_item                   i_item,
    output logic                                empty,
    input  logic                                pop,
    output dsp_pkg::t_out_item                  o_result,
    input  logic                                i_cfg_we,
    input  logic [dsp_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic                                i_cfg_wdata
);

    import dsp_pkg::*;

    logic    r_sign_enable;
    logic    r_wide_mode;
    t_token  w_tok;
    logic    w_tok_empty;
    logic    w_tok_pop;
    t_result w_res_in;
    t_result w_res_out;
    logic    w_res_push;
    logic    w_res_full;
    logic [63:0] w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sign_enable <= 1'b1;
            r_wide_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SIGN_ENABLE: r_sign_enable <= i_cfg_wdata;
                REG_WIDE_MODE:   r_wide_mode   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    dsp_front #(
        .DEPTH (TOKEN_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_item        (i_item),
        .i_sign_enable (r_sign_enable),
        .i_tok_pop     (w_tok_pop),
        .o_tok         (w_tok),
        .o_tok_empty   (w_tok_empty)
    );

    dsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wide_mode (r_wide_mode),
        .i_tok       (w_tok),
        .i_tok_empty (w_tok_empty),
        .o_tok_pop   (w_tok_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    dsp_fifo #(
        .t_data (t_result),
        .DEPTH  (RESULT_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    // sign applied on the way out
    assign w_mag = {1'b0, w_res_out.magnitude};

    always_comb begin
        o_result.parsed_value   = w_res_out.negative ? -$signed(w_mag) : $signed(w_mag);
        o_result.digits_seen    = w_res_out.digits_seen;
        o_result.digits_dropped = w_res_out.digits_dropped;
    end

    `ASSERT_ALWAYS(a_tok_no_underflow, i_clk, i_rst_n, !(w_tok_pop && w_tok_empty))
    `ASSERT_ALWAYS(a_res_no_overflow, i_clk, i_rst_n, !(w_res_push && w_res_full))
    `ASSERT_IMPLIES(a_no_digit_is_zero, i_clk, i_rst_n, !empty && !o_result.digits_seen, o_result.parsed_value == 64'sd0 && !o_result.digits_dropped)

endmodule

@@ design/dsp_fifo.sv @@
// small register queue, one transfer in and one out per cycle; a push is ignored while full and a pop while empty
// depends on nothing but its type parameter
`timescale 1ns / 1ps

module dsp_fifo #(
    parameter type t_data = logic,
    parameter int  DEPTH  = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_data            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ design/dsp_front.sv @@
// front end: classifies each text byte into a token and queues it
// depends on dsp_pkg and dsp_fifo
`timescale 1ns / 1ps

module dsp_front #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  dsp_pkg::t_in_item i_item,
    input  logic              i_sign_enable,
    input  logic              i_tok_pop,
    output dsp_pkg::t_token   o_tok,
    output logic              o_tok_empty
);

    import dsp_pkg::*;

    t_token w_tok;
    logic   w_is_digit;

    assign w_is_digit = (i_item.char_code >= CHAR_ZERO) && (i_item.char_code <= CHAR_NINE);

    always_comb begin
        w_tok.eot   = i_item.end_of_text;
        w_tok.digit = 4'(i_item.char_code - CHAR_ZERO);
        if (i_item.char_code == CHAR_NUL) begin
            w_tok.kind = TK_NUL;
        end else if (w_is_digit) begin
            w_tok.kind = TK_DIGIT;
        end else if (i_item.char_code == CHAR_MINUS && i_sign_enable) begin
            w_tok.kind = TK_MINUS;
        end else begin
            w_tok.kind = TK_OTHER;
        end
    end

    dsp_fifo #(
        .t_data (t_token),
        .DEPTH  (DEPTH)
    ) u_tok_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_tok),
        .o_full  (o_full),
        .i_pop   (i_tok_pop),
        .o_data  (o_tok),
        .o_empty (o_tok_empty)
    );

endmodule

@@ design/dsp_back.sv @@
// back end: number state machine with digit accumulation and result build
// depends on dsp_pkg
`timescale 1ns / 1ps

module dsp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wide_mode,
    input  dsp_pkg::t_token  i_tok,
    input  logic             i_tok_empty,
    output logic             o_tok_pop,
    input  logic             i_res_full,
    output logic             o_res_push,
    output dsp_pkg::t_result o_res
);

    import dsp_pkg::*;

    t_phase           r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic             r_drop, n_drop;

    logic             w_fire;
    logic             w_pending;
    logic [ACC_W-1:0] w_limit;
    logic [ACC_W-1:0] w_acc_mac;
    logic [ACC_W-1:0] w_digit;
    logic             w_at_limit;

    assign w_fire     = !i_tok_empty && !i_res_full;
    assign o_tok_pop  = w_fire;
    assign w_pending  = (r_phase == PH_MINUS) || (r_phase == PH_DIGITS);
    assign w_limit    = i_wide_mode ? LIMIT_WIDE : LIMIT_NARROW;
    assign w_at_limit = (r_acc >= w_limit);
    assign w_digit    = ACC_W'(i_tok.digit);
    // acc * 10 + digit as shift-add
    assign w_acc_mac  = (r_acc << 3) + (r_acc << 1) + w_digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_drop  <= n_drop;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_acc      = r_acc;
        n_drop     = r_drop;
        o_res_push = 1'b0;
        o_res      = '{magnitude: r_acc, negative: r_neg,
                       digits_seen: (r_phase == PH_DIGITS), digits_dropped: r_drop};
        if (w_fire) begin
            case (i_tok.kind)
                TK_NUL: begin
                    o_res_push = w_pending;
                    n_phase    = PH_SKIP;
                    n_neg      = 1'b0;
                    n_acc      = '0;
                    n_drop     = 1'b0;
                end
                TK_DIGIT: begin
                    if (w_pending) begin
                        n_phase = PH_DIGITS;
                        if (w_at_limit) begin
                            n_drop = 1'b1;
                        end else begin
                            n_acc = w_acc_mac;
                        end
                        if (i_tok.eot) begin
                            o_res_push = 1'b1;
                            o_res      = '{magnitude: n_acc, negative: r_neg,
                                           digits_seen: 1'b1, digits_dropped: n_drop};
                            n_phase    = PH_SKIP;
                            n_neg      = 1'b0;
                            n_acc      = '0;
                            n_drop     = 1'b0;
                        end
                    end else if (i_tok.eot) begin
                        o_res_push = 1'b1;
                        o_res      = '{magnitude: w_digit, negative: 1'b0,
                                       digits_seen: 1'b1, digits_dropped: 1'b0};
                        n_phase    = PH_SKIP;
                        n_neg      = 1'b0;
                        n_acc      = '0;
                        n_drop     = 1'b0;
                    end else begin
                        n_phase = PH_DIGITS;
                        n_neg   = 1'b0;
                        n_acc   = w_digit;
                        n_drop  = 1'b0;
                    end
                end
                TK_MINUS: begin
                    o_res_push = w_pending || i_tok.eot;
                    if (!w_pending) begin
                        o_res = '{magnitude: '0, negative: 1'b1,
                                  digits_seen: 1'b0, digits_dropped: 1'b0};
                    end
                    n_acc  = '0;
                    n_drop = 1'b0;
                    if (i_tok.eot) begin
                        n_phase = PH_SKIP;
                        n_neg   = 1'b0;
                    end else begin
                        n_phase = PH_MINUS;
                        n_neg   = 1'b1;
                    end
                end
                default: begin
                    o_res_push = w_pending;
                    n_phase    = PH_SKIP;
                    n_neg      = 1'b0;
                    n_acc      = '0;
                    n_drop     = 1'b0;
                end
            endcase
        end
    end

endmodule

@@ tb/decimal_integer_stream_parser_unit_test.sv @@
// testbench for decimal_integer_stream_parser_unit: byte stream in, parsed numbers checked out
// depends on dsp_pkg and the parser unit; predicts every number in its own state machine
`timescale 1ns / 1ps

module decimal_integer_stream_parser_unit_test;
    import dsp_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int PHASE_BYTES = 370;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    t_in_item              i_item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    t_out_item             o_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic                  i_cfg_wdata = 1'b0;

    t_in_item  text_q[$];
    t_out_item number_q[$];
    t_out_item fresh_number;
    t_out_item want;

    // predictor state and register copies
    t_phase      ph = PH_SKIP;
    bit          neg = 1'b0;
    logic [62:0] acc = '0;
    bit          dropped = 1'b0;
    bit          sign_en = 1'b1;
    bit          wide = 1'b0;

    bit gaps_on = 1'b1;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int bytes_sent = 0;
    int fault_count = 0;

    decimal_integer_stream_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("decimal_integer_stream_parser_unit_test NOT OK");
        $finish;
    end

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic void clear_number();
        ph = PH_SKIP;
        neg = 1'b0;
        acc = '0;
        dropped = 1'b0;
    endfunction

    function automatic void finish_number(output t_out_item r);
        logic signed [63:0] v;
        v = {1'b0, acc};
        if (neg) v = -v;
        r.parsed_value = v;
        r.digits_seen = (ph == PH_DIGITS);
        r.digits_dropped = dropped;
    endfunction

    function automatic void start_number(input logic [7:0] c);
        clear_number();
        if (is_digit(c)) begin
            ph = PH_DIGITS;
            acc = 63'(c - CHAR_ZERO);
        end else if (c == CHAR_MINUS && sign_en) begin
            ph = PH_MINUS;
            neg = 1'b1;
        end
    endfunction

    function automatic bit parse_byte(input t_in_item it, output t_out_item r);
        logic [7:0]  c;
        bit          eot;
        bit          busy;
        logic [62:0] lim;
        c = it.char_code;
        eot = it.end_of_text;
        busy = (ph == PH_MINUS || ph == PH_DIGITS);
        r = '0;
        if (c == CHAR_NUL) begin
            if (busy) finish_number(r);
            clear_number();
            return busy;
        end
        if (busy && is_digit(c)) begin
            lim = wide ? LIMIT_WIDE : LIMIT_NARROW;
            ph = PH_DIGITS;
            if (acc >= lim) dropped = 1'b1;
            else acc = acc * 63'd10 + 63'(c - CHAR_ZERO);
            if (eot) begin
                finish_number(r);
                clear_number();
                return 1'b1;
            end
            return 1'b0;
        end
        if (busy) begin
            // a non-digit closes the number and, when it does not end the text, is looked at again
            finish_number(r);
            clear_number();
            if (!eot) start_number(c);
            return 1'b1;
        end
        start_number(c);
        if (eot) begin
            busy = (ph != PH_SKIP);
            if (busy) finish_number(r);
            clear_number();
            return busy;
        end
        return 1'b0;
    endfunction

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            i_item <= '0;
        end else begin
            if (push && !full) begin
                if (parse_byte(i_item, fresh_number)) number_q.push_back(fresh_number);
                void'(text_q.pop_front());
                bytes_sent++;
            end
            if (text_q.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 38)) begin
                push <= 1'b1;
                i_item <= text_q[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (number_q.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected result: value %0d seen %0b dropped %0b",
                                 o_result.parsed_value, o_result.digits_seen,
                                 o_result.digits_dropped);
                end else begin
                    want = number_q.pop_front();
                    if (o_result.parsed_value !== want.parsed_value ||
                        o_result.digits_seen !== want.digits_seen ||
                        o_result.digits_dropped !== want.digits_dropped) begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     want.parsed_value, want.digits_seen,
                                     want.digits_dropped, o_result.parsed_value,
                                     o_result.digits_seen, o_result.digits_dropped);
                    end
                end
            end
            // long receiver stall so the input side backs up
            if (!hold_done && bytes_sent >= 200) begin
                hold_left = 150;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= !(gaps_on && $urandom_range(0, 99) < 38);
            end
        end
    end

    function automatic void put_char(input logic [7:0] c, input bit eot);
        t_in_item it;
        it.char_code = c;
        it.end_of_text = eot;
        text_q.push_back(it);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i], 1'b0);
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_digit(c));
        return c;
    endfunction

    // random number text, possibly without digits; returns bytes queued
    function automatic int add_number();
        int    n;
        int    pick;
        int    count;
        string sep;
        count = text_q.size();
        if ($urandom_range(0, 2) == 0) put_char(CHAR_MINUS, 1'b0);
        pick = $urandom_range(0, 19);
        if (pick == 0) n = $urandom_range(20, 24);
        else if (pick == 1) begin
            put_text("21474836");
            n = $urandom_range(0, 4);
        end else if (pick == 2) begin
            put_text("92233720368547758");
            n = $urandom_range(0, 4);
        end else if (pick < 5) n = $urandom_range(9, 12);
        else n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) put_char(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        sep = " ,;";
        case ($urandom_range(0, 7))
            0: put_char(CHAR_NUL, $urandom_range(0, 1) == 1);
            1: if (text_q.size() != 0) text_q[text_q.size() - 1].end_of_text = 1'b1;
            2: put_char(CHAR_MINUS, $urandom_range(0, 3) == 0);
            3: put_char(non_digit(), 1'b1);
            4: put_char(sep[$urandom_range(0, 2)], 1'b0);
            default: put_char(non_digit(), 1'b0);
        endcase
        return text_q.size() - count;
    endfunction

    task automatic fill_phase(input int target);
        int count;
        count = 0;
        while (count < target) begin
            count += add_number();
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    put_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic drain();
        while (text_q.size() != 0 || number_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input bit val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_SIGN_ENABLE) sign_en = val;
        else if (idx == REG_WIDE_MODE) wide = val;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        put_text("0 ");
        put_text("9/");
        put_text(":");
        put_text("-x");
        put_text("-7-8,");
        put_char(CHAR_NUL, 1'b0);
        put_text("5");
        put_char(CHAR_NUL, 1'b1);
        put_char(8'hFF, 1'b1);
        put_char(CHAR_MINUS, 1'b1);
        put_char("4", 1'b1);
        put_text("12");
        put_char("3", 1'b1);
        put_text("6");
        put_char("a", 1'b1);
        put_text("3");
        put_char(CHAR_MINUS, 1'b1);
        fill_phase(PHASE_BYTES - 25);
        drain();

        write_reg(REG_SIGN_ENABLE, 1'b0);
        write_reg(REG_SPARE_LO, 1'b1);
        write_reg(REG_SPARE_HI, 1'b1);
        fill_phase(PHASE_BYTES);
        drain();

        write_reg(REG_WIDE_MODE, 1'b1);
        gaps_on = 1'b0;
        fill_phase(PHASE_BYTES);
        drain();
        gaps_on = 1'b1;

        write_reg(REG_SIGN_ENABLE, 1'b1);
        fill_phase(PHASE_BYTES);
        drain();

        write_reg(REG_WIDE_MODE, 1'b0);
        fill_phase(PHASE_BYTES);
        drain();
        repeat (10) @(posedge i_clk);

        if (fault_count == 0 && number_q.size() == 0)
            $display("decimal_integer_stream_parser_unit_test OK");
        else
            $display("decimal_integer_stream_parser_unit_test NOT OK");
        $finish;
    end

endmodule

@@ decimal_integer_stream_parser_unit.f @@
+incdir+design
design/dsp_pkg.sv
design/dsp_fifo.sv
design/dsp_front.sv
design/dsp_back.sv
design/decimal_integer_stream_parser_unit.sv
tb/decimal_integer_stream_parser_unit_test.sv
